// ===== design/iir3_pkg.sv =====
// iir3_pkg: shared widths, constants, codes and the control struct for the
// third-order direct form II filter
// no dependencies
package iir3_pkg;

  // field and datapath widths
  localparam int DATA_W     = 8;
  localparam int COEF_W     = 11;
  localparam int STATE_W    = 16;
  localparam int FRAC_SHIFT = COEF_W - 1;
  localparam int ALIGN      = COEF_W - DATA_W;
  localparam int TAPS       = 3;
  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);

  // product, scaled product and accumulator widths
  localparam int PROD_W = STATE_W + COEF_W;
  localparam int SHP_W  = PROD_W - FRAC_SHIFT;
  localparam int ACC_W  = SHP_W + 3;

  // run steps of the shared multiplier
  localparam int NUM_STEPS = 8;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef logic signed [DATA_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef coef_t [NUM_REGS-1:0]      coef_bank_t;

  // saturation bounds in accumulator width
  localparam acc_t W_MAX = ACC_W'((1 <<< (STATE_W - 1)) - 1);
  localparam acc_t W_MIN = ACC_W'(-(1 <<< (STATE_W - 1)));
  localparam acc_t Y_MAX = ACC_W'((1 <<< (DATA_W - 1)) - 1);
  localparam acc_t Y_MIN = ACC_W'(-(1 <<< (DATA_W - 1)));

  // coefficient register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FB1 = 3'd0,
    REG_FB2 = 3'd1,
    REG_FB3 = 3'd2,
    REG_FF0 = 3'd3,
    REG_FF1 = 3'd4,
    REG_FF2 = 3'd5,
    REG_FF3 = 3'd6
  } reg_idx_t;

  // coefficient reset values, register 0 in the lowest bits
  localparam coef_bank_t COEF_RESET = {
    COEF_W'(78), COEF_W'(364), COEF_W'(494), COEF_W'(208),
    COEF_W'(75), COEF_W'(-56), COEF_W'(0)
  };

  // multiplier operand a
  typedef enum logic [1:0] {
    OPA_D0,
    OPA_D1,
    OPA_D2,
    OPA_W
  } opa_sel_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_SUB,
    ACC_ADD,
    ACC_LOAD
  } acc_op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic     x_load;
    logic     mul_en;
    opa_sel_t opa_sel;
    reg_idx_t coef_sel;
    acc_op_t  acc_op;
    logic     w_load;
    logic     out_load;
  } dp_ctrl_t;

endpackage

// ===== design/iir3_top.sv =====
// iir_third_order_df2_fixed_top: third-order direct form II fixed-point filter
// depends on iir3_pkg, iir3_coef_regs, iir3_seq, iir3_datapath
//
// Usage
//   in_*  : one signed 8-bit sample per transfer, in_tdata[7:0].
//   out_* : one saturated signed 8-bit sample per input, out_tdata[7:0].
//   cfg_* : coefficient writes, cfg_index 0..6 selects fb_coef_1..3,
//           ff_coef_0..3; index 7 is ignored. cfg_ready is always high.
//           Write only while no sample is in flight.
// Timing
//   One 16x11 multiplier is shared over eight steps (three feedback
//   products, four feedforward products, w is formed in between).
//   After an input transfer the sequencer runs the steps and a done
//   state; the result turns valid and in_tready returns at the same edge.
//   in_tready is low while a sample is being computed.
// Reset and stalls
//   rst_n (synchronous, active low) clears the delay line and restores
//   the default coefficients. A result waiting in the output register
//   does not block the next input; if it has still not been taken when
//   the next result is ready, the sequencer holds until it is.
module iir_third_order_df2_fixed_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] sample_in
  // output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] sample_out
  // coefficient writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iir3_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [iir3_pkg::COEF_W-1:0]    cfg_data
);
  import iir3_pkg::*;

  coef_bank_t coefs;
  dp_ctrl_t   ctrl;
  sample_t    sample_out;

  // coefficient registers
  iir3_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // sequencer
  iir3_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  // arithmetic and state
  iir3_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sample_in  (sample_t'(in_tdata)),
    .coefs      (coefs),
    .sample_out (sample_out)
  );

  assign out_tdata = sample_out;

endmodule

// ===== design/iir3_coef_regs.sv =====
// iir3_coef_regs: the seven coefficient registers and their write port
// depends on iir3_pkg
module iir3_coef_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [iir3_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [iir3_pkg::COEF_W-1:0]   cfg_data,
  output iir3_pkg::coef_bank_t          coefs
);
  import iir3_pkg::*;

  coef_bank_t coef_r;

  // always able to take a write
  assign cfg_ready = 1'b1;
  assign coefs     = coef_r;

  // register write, indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

endmodule

// ===== design/iir3_datapath.sv =====
// iir3_datapath: shared 16x11 multiplier, accumulator, delay line,
// intermediate word and output sample register
// depends on iir3_pkg
module iir3_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iir3_pkg::dp_ctrl_t   ctrl,
  input  iir3_pkg::sample_t    sample_in,
  input  iir3_pkg::coef_bank_t coefs,
  output iir3_pkg::sample_t    sample_out
);
  import iir3_pkg::*;

  sample_t x_r;
  state_t  delay_r [TAPS];
  state_t  w_r;
  prod_t   prod_r;
  acc_t    acc_r;
  sample_t out_r;

  state_t  op_a;
  coef_t   op_b;
  prod_t   prod_nxt;
  logic signed [SHP_W-1:0] term_s;
  acc_t    term;
  acc_t    acc_nxt;
  acc_t    w_sum;
  state_t  w_nxt;
  acc_t    y_sh;
  sample_t y_nxt;

  // operand selection
  always_comb begin
    case (ctrl.opa_sel)
      OPA_D0:  op_a = delay_r[0];
      OPA_D1:  op_a = delay_r[1];
      OPA_D2:  op_a = delay_r[2];
      OPA_W:   op_a = w_r;
      default: op_a = w_r;
    endcase
    op_b = coefs[ctrl.coef_sel];
  end

  // shared multiplier, product registered
  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  // product scaled by the fraction shift (floor)
  assign term_s = prod_r[PROD_W-1:FRAC_SHIFT];
  assign term   = ACC_W'(term_s);

  // accumulator update
  always_comb begin
    case (ctrl.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_CLR:  acc_nxt = '0;
      ACC_SUB:  acc_nxt = acc_r - term;
      ACC_ADD:  acc_nxt = acc_r + term;
      ACC_LOAD: acc_nxt = term;
      default:  acc_nxt = acc_r;
    endcase
  end

  // intermediate word: aligned input plus feedback, saturated
  always_comb begin
    w_sum = acc_r + (ACC_W'(x_r) <<< ALIGN);
    if (w_sum > W_MAX) begin
      w_nxt = W_MAX[STATE_W-1:0];
    end else if (w_sum < W_MIN) begin
      w_nxt = W_MIN[STATE_W-1:0];
    end else begin
      w_nxt = w_sum[STATE_W-1:0];
    end
  end

  // output: feedforward sum shifted back down, saturated
  always_comb begin
    y_sh = acc_r >>> ALIGN;
    if (y_sh > Y_MAX) begin
      y_nxt = Y_MAX[DATA_W-1:0];
    end else if (y_sh < Y_MIN) begin
      y_nxt = Y_MIN[DATA_W-1:0];
    end else begin
      y_nxt = y_sh[DATA_W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.x_load) begin
      x_r <= sample_in;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (ctrl.w_load) begin
      w_r <= w_nxt;
    end
    if (ctrl.out_load) begin
      out_r <= y_nxt;
    end
  end

  // delay line shifts in w when the result is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        delay_r[i] <= '0;
      end
    end else if (ctrl.out_load) begin
      for (int i = TAPS - 1; i > 0; i--) begin
        delay_r[i] <= delay_r[i-1];
      end
      delay_r[0] <= w_r;
    end
  end

  assign sample_out = out_r;

endmodule

// ===== design/iir3_seq.sv =====
// iir3_seq: sequencer for the shared multiplier and the stream handshakes
// depends on iir3_pkg
module iir3_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output iir3_pkg::dp_ctrl_t ctrl
);
  import iir3_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              in_xfer;
  logic              out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_xfer) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ctrl          = '0;
    ctrl.opa_sel  = OPA_D0;
    ctrl.coef_sel = REG_FB1;
    ctrl.acc_op   = ACC_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.x_load = 1'b1;
          ctrl.acc_op = ACC_CLR;
        end
      end
      ST_RUN: begin
        case (step_r)
          3'd0: begin
            ctrl.mul_en = 1'b1;
          end
          3'd1: begin
            ctrl.mul_en   = 1'b1;
            ctrl.opa_sel  = OPA_D1;
            ctrl.coef_sel = REG_FB2;
            ctrl.acc_op   = ACC_SUB;
          end
          3'd2: begin
            ctrl.mul_en   = 1'b1;
            ctrl.opa_sel  = OPA_D2;
            ctrl.coef_sel = REG_FB3;
            ctrl.acc_op   = ACC_SUB;
          end
          3'd3: begin
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = REG_FF1;
            ctrl.acc_op   = ACC_SUB;
          end
          3'd4: begin
            // feedback complete: form w, restart the sum on the first ff term
            ctrl.mul_en   = 1'b1;
            ctrl.opa_sel  = OPA_D1;
            ctrl.coef_sel = REG_FF2;
            ctrl.acc_op   = ACC_LOAD;
            ctrl.w_load   = 1'b1;
          end
          3'd5: begin
            ctrl.mul_en   = 1'b1;
            ctrl.opa_sel  = OPA_D2;
            ctrl.coef_sel = REG_FF3;
            ctrl.acc_op   = ACC_ADD;
          end
          3'd6: begin
            ctrl.mul_en   = 1'b1;
            ctrl.opa_sel  = OPA_W;
            ctrl.coef_sel = REG_FF0;
            ctrl.acc_op   = ACC_ADD;
          end
          default: begin
            ctrl.acc_op = ACC_ADD;
          end
        endcase
      end
      ST_DONE: begin
        ctrl.out_load = out_free;
      end
      default: ctrl.acc_op = ACC_HOLD;
    endcase
  end

  // output valid flag
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (ctrl.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a transfer always starts the run at its first step
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_RUN) && (step_r == '0))
    else $error("run did not start after input transfer");

  // the last step hands over to the result stage
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (step_r == STEP_W'(NUM_STEPS - 1)) |=> (state_r == ST_DONE))
    else $error("run did not finish after last step");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten while stalled");

  // a result issue is followed by valid output
  a_issue_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_tvalid_r && (state_r == ST_IDLE))
    else $error("issued result not presented");
`endif

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the third-order direct form II filter
// depends on iir3_pkg and iir_third_order_df2_fixed_top
// a scoreboard class predicts each output sample, plain tasks drive the streams
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iir3_pkg::*;

  // index that lies past the last coefficient register, writes to it are dropped
  localparam logic [REG_IDX_W-1:0] IDX_UNUSED = REG_IDX_W'(NUM_REGS);
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 200;

  // sample patterns for the random part
  typedef enum int {
    PAT_NOISE,
    PAT_SMALL,
    PAT_STEP,
    PAT_ALTERNATE,
    PAT_IMPULSE
  } pattern_t;

  // scoreboard: filter state, coefficient copy and the queue of expected samples
  class filter_scoreboard;
    coef_t   coef[NUM_REGS];
    state_t  taps[TAPS];
    sample_t expected_samples[$];
    int      fail_count;

    function void reset_state();
      for (int i = 0; i < NUM_REGS; i++) coef[i] = COEF_RESET[i];
      for (int i = 0; i < TAPS; i++) taps[i] = '0;
      expected_samples.delete();
      fail_count = 0;
    endfunction

    function void write_coef(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      if (idx < NUM_REGS) coef[idx] = coef_t'(value);
    endfunction

    // one filter step, updates the delay line and returns the output sample
    function sample_t filtered_sample(sample_t x);
      longint fb_sum;
      longint ff_sum;
      longint w;
      longint y;
      fb_sum = 0;
      ff_sum = 0;
      for (int i = 0; i < TAPS; i++) begin
        fb_sum -= (longint'(taps[i]) * longint'(coef[int'(REG_FB1) + i])) >>> FRAC_SHIFT;
        ff_sum += (longint'(taps[i]) * longint'(coef[int'(REG_FF1) + i])) >>> FRAC_SHIFT;
      end
      // intermediate word, saturated to the state width
      w = (longint'(x) <<< ALIGN) + fb_sum;
      if (w > longint'(W_MAX)) w = longint'(W_MAX);
      if (w < longint'(W_MIN)) w = longint'(W_MIN);
      // output, scaled back and saturated to the sample width
      y = ((w * longint'(coef[REG_FF0])) >>> FRAC_SHIFT) + ff_sum;
      y = y >>> ALIGN;
      if (y > longint'(Y_MAX)) y = longint'(Y_MAX);
      if (y < longint'(Y_MIN)) y = longint'(Y_MIN);
      for (int i = TAPS - 1; i > 0; i--) taps[i] = taps[i-1];
      taps[0] = state_t'(w);
      return sample_t'(y);
    endfunction

    function void note_input(sample_t x);
      expected_samples.push_back(filtered_sample(x));
    endfunction

    function void check_output(sample_t actual);
      sample_t want;
      if (expected_samples.size() == 0) begin
        $error("output transfer with no sample pending, got sample_out %0d", actual);
        fail_count++;
        return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want, actual);
        fail_count++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  filter_scoreboard sb;
  bit quiet;
  int hold_left;

  iir_third_order_df2_fixed_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock, period 2 ns
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (cfg_valid && cfg_ready) sb.write_coef(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_input(sample_t'(in_tdata));
      if (out_tvalid && out_tready) sb.check_output(sample_t'(out_tdata));
    end
  end

  // receiver: random stalls, plus a long hold when one is requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  // one coefficient write transfer
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // write every register with one value, and the dropped index with another
  task automatic load_all_coefs(logic [COEF_W-1:0] value);
    reg_idx_t r;
    r = r.first();
    do begin
      write_reg(r, value);
      r = r.next();
    end while (r != r.first());
    write_reg(IDX_UNUSED, ~value);
  endtask

  task automatic load_random_coefs();
    reg_idx_t r;
    r = r.first();
    do begin
      write_reg(r, COEF_W'($urandom_range(2047)));
      r = r.next();
    end while (r != r.first());
  endtask

  // one input transfer, with a random gap in front of it
  task automatic send_sample(logic [7:0] x);
    if (!quiet && $urandom_range(99) < 6) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = x;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold the input until every pending sample has come out
  task automatic wait_drained();
    in_tvalid = 1'b0;
    do @(negedge clk); while (sb.expected_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // bursts of patterned samples with random content
  task automatic send_random(int count);
    pattern_t   pat;
    int         len;
    logic [7:0] level;
    logic [7:0] x;
    int         sent;
    sent = 0;
    while (sent < count) begin
      pat   = pattern_t'($urandom_range(4));
      len   = $urandom_range(4, 32);
      level = 8'($urandom_range(255));
      for (int k = 0; k < len && sent < count; k++) begin
        case (pat)
          PAT_NOISE:     x = 8'($urandom_range(255));
          PAT_SMALL:     x = 8'($urandom_range(8) - 4);
          PAT_STEP:      x = level;
          PAT_ALTERNATE: x = k[0] ? 8'h80 : 8'h7f;
          default:       x = (k == 0) ? level : 8'h00;
        endcase
        send_sample(x);
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    logic [7:0] directed[$];
    sb = new();
    sb.reset_state();
    quiet      = 1'b0;
    hold_left  = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients: extremes, sign changes, runs that drive saturation
    directed = '{8'h00, 8'h7f, 8'h80, 8'h01, 8'hff, 8'h00,
                 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
                 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                 8'h7f, 8'h80, 8'h7f, 8'h80, 8'h00, 8'h00};
    foreach (directed[i]) send_sample(directed[i]);
    send_random(300);
    wait_drained();

    // most negative coefficients, long output hold while input keeps coming
    load_all_coefs(11'h400);
    send_random(60);
    hold_left = LONG_HOLD;
    send_random(240);
    wait_drained();

    // most positive coefficients, no idling on either side
    quiet = 1'b1;
    load_all_coefs(11'h3ff);
    send_random(300);
    wait_drained();
    quiet = 1'b0;

    // feedforward only, large feedback only
    load_all_coefs(11'h000);
    write_reg(REG_FF0, 11'h3ff);
    send_random(150);
    wait_drained();
    write_reg(REG_FF0, 11'h001);
    write_reg(REG_FB1, 11'h400);
    write_reg(REG_FB3, 11'h3ff);
    send_random(150);
    wait_drained();

    // random coefficient sets
    repeat (3) begin
      load_random_coefs();
      send_random(250);
      wait_drained();
    end

    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/iir3_pkg.sv
design/iir3_coef_regs.sv
design/iir3_datapath.sv
design/iir3_seq.sv
design/iir3_top.sv
bench/testbench.sv
